@@ sv/nfasc_pkg.sv @@
// shared constants, codes and types of the nfa subset construction unit
package nfasc_pkg;

    localparam int DEF_MAX_DFA_STATES = 256;
    localparam int DEF_MAX_NFA_STATES = 64;
    localparam int DEF_MAX_SYMBOLS    = 26;

    localparam int MASK_W  = 64;
    localparam int MASK_IW = 6;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int SYM_W   = 5;
    localparam int NST_W   = 7;
    localparam int CMD_W   = 3;
    localparam int STS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FINAL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd1;
    localparam logic [STS_W-1:0] STS_UNBUILT  = 2'd2;

    localparam logic [7:0] REG_NUM_SYMBOLS = 8'd0;
    localparam logic [7:0] REG_NUM_STATES  = 8'd1;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [CNT_W-1:0]  dfa_count;
        logic              has_trash;
        logic [IDX_W-1:0]  trash_index;
        logic [IDX_W-1:0]  next_index;
        logic              is_final;
        logic [MASK_W-1:0] subset_mask;
    } t_result;

endpackage

@@ sv/nfa_subset_construction_unit.sv @@
// nfa to dfa subset construction unit: transition stores, build sequencer, table read
// commands: mark and unknown ones keep the input ready; load does a read-modify-write of the
//   delta word in S_LDWR; read goes through S_RDD (skipped when unbuilt) and S_EMIT
// build: per dfa state a subset read, then per symbol one delta read per nfa state and up to
//   one subset read per known subset, issued one at a time
// reset: synchronous active low; the delta store is then zeroed by a clearing pass over
//   MAX_NFA_STATES * MAX_SYMBOLS words (1664 by default) with the input not ready
module nfa_subset_construction_unit #(
    parameter int MAX_DFA_STATES = nfasc_pkg::DEF_MAX_DFA_STATES,
    parameter int MAX_NFA_STATES = nfasc_pkg::DEF_MAX_NFA_STATES,
    parameter int MAX_SYMBOLS    = nfasc_pkg::DEF_MAX_SYMBOLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: src_state[5:0], symbol[10:6], dst_state[16:11], dfa_index[24:17]
    input  logic [31:0] s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: dfa_count[8:0], has_trash[9], trash_index[17:10], next_index[25:18],
    //        is_final[26], subset_mask[90:27]
    output logic [95:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]  m_axis_tuser,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int DDEPTH = MAX_NFA_STATES * MAX_SYMBOLS;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int SAW    = (MAX_DFA_STATES > 1) ? $clog2(MAX_DFA_STATES) : 1;
    localparam int TDEPTH = MAX_DFA_STATES * MAX_SYMBOLS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TW     = nfasc_pkg::IDX_W + 1;
    localparam int MW     = nfasc_pkg::MASK_W;
    localparam int CW     = nfasc_pkg::CNT_W;
    localparam int MASK_IW_W = nfasc_pkg::MASK_IW;

    // sequencer states
    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_LDWR  = 10'b00_0000_0100,
        S_BROW  = 10'b00_0000_1000,
        S_BROWD = 10'b00_0001_0000,
        S_BSUCC = 10'b00_0010_0000,
        S_BSRCH = 10'b00_0100_0000,
        S_BNEXT = 10'b00_1000_0000,
        S_RDD   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration and nfa marks
    logic [nfasc_pkg::SYM_W-1:0] r_num_sym, n_num_sym;
    logic [nfasc_pkg::NST_W-1:0] r_num_st, n_num_st;
    logic [MW-1:0]               r_init, n_init;
    logic [MW-1:0]               r_final, n_final;

    // build bookkeeping
    logic [CW-1:0]               r_total, n_total;
    logic [CW-1:0]               r_head, n_head;
    logic                        r_built, n_built;
    logic                        r_trash, n_trash;
    logic                        r_need, n_need;
    logic [MW-1:0]               r_set, n_set;
    logic [MW-1:0]               r_acc, n_acc;
    logic [nfasc_pkg::SYM_W-1:0] r_s, n_s;
    logic [nfasc_pkg::NST_W-1:0] r_e, n_e;
    logic [CW-1:0]               r_j, n_j;
    logic [CW-1:0]               r_pj, n_pj;
    logic                        r_pv, n_pv;
    logic                        r_pbit, n_pbit;
    logic [DAW-1:0]              r_clr, n_clr;

    // request fields held across multi-cycle commands
    logic [DAW-1:0]              r_daddr, n_daddr;
    logic [MASK_IW_W-1:0]        r_dst, n_dst;
    logic [nfasc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [nfasc_pkg::SYM_W-1:0] r_sym, n_sym;

    // result staging and output register
    nfasc_pkg::t_result r_res, n_res;
    nfasc_pkg::t_result r_out, n_out;
    logic               r_ov, n_ov;

    // memory ports
    logic           d_we;
    logic [DAW-1:0] d_waddr, d_raddr;
    logic [MW-1:0]  d_wdata, d_rdata;
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [MW-1:0]  s_wdata, s_rdata;
    logic           t_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [TW-1:0]  t_wdata, t_rdata;

    // request field unpacking
    logic [nfasc_pkg::CMD_W-1:0] req_cmd;
    logic [5:0]                  req_src;
    logic [nfasc_pkg::SYM_W-1:0] req_sym;
    logic [5:0]                  req_dst;
    logic [nfasc_pkg::IDX_W-1:0] req_idx;
    logic                        req_acc;

    assign req_cmd = s_axis_tuser;
    assign req_src = s_axis_tdata[5:0];
    assign req_sym = s_axis_tdata[10:6];
    assign req_dst = s_axis_tdata[16:11];
    assign req_idx = s_axis_tdata[24:17];
    assign s_axis_tready = (r_state == S_IDLE);
    assign req_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = (r_state == S_IDLE);

    // effective alphabet size and state count, clamped to the supported range
    logic [nfasc_pkg::SYM_W-1:0] ns_eff;
    logic [nfasc_pkg::NST_W-1:0] n_eff;

    always_comb begin
        if (r_num_sym == '0) begin
            ns_eff = nfasc_pkg::SYM_W'(1);
        end else if (r_num_sym > nfasc_pkg::SYM_W'(MAX_SYMBOLS)) begin
            ns_eff = nfasc_pkg::SYM_W'(MAX_SYMBOLS);
        end else begin
            ns_eff = r_num_sym;
        end
        if (r_num_st == '0) begin
            n_eff = nfasc_pkg::NST_W'(1);
        end else if (r_num_st > nfasc_pkg::NST_W'(MAX_NFA_STATES)) begin
            n_eff = nfasc_pkg::NST_W'(MAX_NFA_STATES);
        end else begin
            n_eff = r_num_st;
        end
    end

    // address arithmetic: row times MAX_SYMBOLS plus symbol
    logic [31:0] req_daddr_w, succ_daddr_w, row_taddr_w, req_taddr_w;

    assign req_daddr_w  = 32'(req_src) * 32'(MAX_SYMBOLS) + 32'(req_sym);
    assign succ_daddr_w = 32'(r_e) * 32'(MAX_SYMBOLS) + 32'(r_s);
    assign row_taddr_w  = 32'(r_head) * 32'(MAX_SYMBOLS) + 32'(r_s);
    assign req_taddr_w  = 32'(req_idx) * 32'(MAX_SYMBOLS) + 32'(req_sym);

    // read entry decode
    logic          rd_in_range, rd_is_trash;
    logic [CW-1:0] total_m1;

    assign total_m1    = r_total - CW'(1);
    assign rd_in_range = CW'(r_idx) < r_total;
    assign rd_is_trash = r_trash && (CW'(r_idx) == total_m1);

    always_comb begin
        n_state   = r_state;
        n_num_sym = r_num_sym;
        n_num_st  = r_num_st;
        n_init    = r_init;
        n_final   = r_final;
        n_total   = r_total;
        n_head    = r_head;
        n_built   = r_built;
        n_trash   = r_trash;
        n_need    = r_need;
        n_set     = r_set;
        n_acc     = r_acc;
        n_s       = r_s;
        n_e       = r_e;
        n_j       = r_j;
        n_pj      = r_pj;
        n_pv      = r_pv;
        n_pbit    = r_pbit;
        n_clr     = r_clr;
        n_daddr   = r_daddr;
        n_dst     = r_dst;
        n_idx     = r_idx;
        n_sym     = r_sym;
        n_res     = r_res;
        n_out     = r_out;
        n_ov      = r_ov && !m_axis_tready;

        d_we    = 1'b0;
        d_waddr = r_daddr;
        d_wdata = d_rdata | (MW'(1) << r_dst);
        d_raddr = r_daddr;
        s_we    = 1'b0;
        s_waddr = r_total[SAW-1:0];
        s_wdata = r_acc;
        s_raddr = r_head[SAW-1:0];
        t_we    = 1'b0;
        t_waddr = row_taddr_w[TAW-1:0];
        t_wdata = '0;
        t_raddr = req_taddr_w[TAW-1:0];

        // register writes only land while idle
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == nfasc_pkg::REG_NUM_SYMBOLS) begin
                n_num_sym = i_cfg_data[nfasc_pkg::SYM_W-1:0];
                n_built   = 1'b0;
            end else if (i_cfg_index == nfasc_pkg::REG_NUM_STATES) begin
                n_num_st = i_cfg_data[nfasc_pkg::NST_W-1:0];
                n_built  = 1'b0;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                d_we    = 1'b1;
                d_waddr = r_clr;
                d_wdata = '0;
                n_clr   = r_clr + DAW'(1);
                if (r_clr == DAW'(DDEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                d_raddr = req_daddr_w[DAW-1:0];
                s_raddr = req_idx[SAW-1:0];
                if (req_acc) begin
                    n_daddr = req_daddr_w[DAW-1:0];
                    n_dst   = req_dst;
                    n_idx   = req_idx;
                    n_sym   = req_sym;
                    unique case (req_cmd)
                        nfasc_pkg::CMD_LOAD: begin
                            n_built = 1'b0;
                            // out-of-range transitions change nothing but the built mark
                            if (32'(req_src) < 32'(MAX_NFA_STATES) &&
                                32'(req_sym) < 32'(MAX_SYMBOLS)) begin
                                n_state = S_LDWR;
                            end
                        end
                        nfasc_pkg::CMD_INIT: begin
                            n_init  = r_init | (MW'(1) << req_src);
                            n_built = 1'b0;
                        end
                        nfasc_pkg::CMD_FINAL: begin
                            n_final = r_final | (MW'(1) << req_src);
                            n_built = 1'b0;
                        end
                        nfasc_pkg::CMD_BUILD: begin
                            // state 0 is the initial set
                            s_we    = 1'b1;
                            s_waddr = '0;
                            s_wdata = r_init;
                            n_total = CW'(1);
                            n_head  = '0;
                            n_need  = 1'b0;
                            n_state = S_BROW;
                        end
                        nfasc_pkg::CMD_READ: begin
                            if (r_built) begin
                                n_state = S_RDD;
                            end else begin
                                n_res        = '0;
                                n_res.status = nfasc_pkg::STS_UNBUILT;
                                n_state      = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LDWR: begin
                // read-modify-write of the delta word fetched last cycle
                d_we    = 1'b1;
                n_state = S_IDLE;
            end
            S_BROW: begin
                n_state = S_BROWD;
            end
            S_BROWD: begin
                n_set   = s_rdata;
                n_s     = '0;
                n_e     = '0;
                n_acc   = '0;
                n_pv    = 1'b0;
                n_state = S_BSUCC;
            end
            S_BSUCC: begin
                // one delta word issued per cycle, or-ed in when its state is in the set
                d_raddr = succ_daddr_w[DAW-1:0];
                if (r_e < n_eff) begin
                    n_e    = r_e + nfasc_pkg::NST_W'(1);
                    n_pv   = 1'b1;
                    n_pbit = r_set[r_e[MASK_IW_W-1:0]];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && r_pbit) begin
                    n_acc = r_acc | d_rdata;
                end
                if (r_e == n_eff && !r_pv) begin
                    if (r_acc == '0) begin
                        // empty successor: mark entry for the trash state
                        t_we    = 1'b1;
                        t_wdata = {1'b1, nfasc_pkg::IDX_W'(0)};
                        n_need  = 1'b1;
                        n_state = S_BNEXT;
                    end else begin
                        n_j     = '0;
                        n_pv    = 1'b0;
                        n_state = S_BSRCH;
                    end
                end
            end
            S_BSRCH: begin
                // linear search of known subsets, one per cycle
                s_raddr = r_j[SAW-1:0];
                if (r_j < r_total) begin
                    n_j  = r_j + CW'(1);
                    n_pv = 1'b1;
                    n_pj = r_j;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && s_rdata == r_acc) begin
                    t_we    = 1'b1;
                    t_wdata = {1'b0, r_pj[nfasc_pkg::IDX_W-1:0]};
                    n_pv    = 1'b0;
                    n_state = S_BNEXT;
                end else if (r_j == r_total && !r_pv) begin
                    if (r_total >= CW'(MAX_DFA_STATES)) begin
                        n_res        = '0;
                        n_res.status = nfasc_pkg::STS_OVERFLOW;
                        n_total      = '0;
                        n_trash      = 1'b0;
                        n_built      = 1'b0;
                        n_state      = S_EMIT;
                    end else begin
                        // new subset appended at the end of the discovery order
                        s_we    = 1'b1;
                        t_we    = 1'b1;
                        t_wdata = {1'b0, r_total[nfasc_pkg::IDX_W-1:0]};
                        n_total = r_total + CW'(1);
                        n_state = S_BNEXT;
                    end
                end
            end
            S_BNEXT: begin
                if (r_s == ns_eff - nfasc_pkg::SYM_W'(1)) begin
                    n_head = r_head + CW'(1);
                    if (r_head + CW'(1) == r_total) begin
                        // work list drained: add trash state if any entry was empty, or report overflow if no room
                        n_res = '0;
                        if (r_need && r_total >= CW'(MAX_DFA_STATES)) begin
                            n_res.status = nfasc_pkg::STS_OVERFLOW;
                            n_total      = '0;
                            n_trash      = 1'b0;
                            n_built      = 1'b0;
                        end else begin
                            n_res.status    = nfasc_pkg::STS_OK;
                            n_built         = 1'b1;
                            n_trash         = r_need;
                            n_res.has_trash = r_need;
                            if (r_need) begin
                                n_total           = r_total + CW'(1);
                                n_res.dfa_count   = r_total + CW'(1);
                                n_res.trash_index = r_total[nfasc_pkg::IDX_W-1:0];
                            end else begin
                                n_res.dfa_count = r_total;
                            end
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_BROW;
                    end
                end else begin
                    n_s     = r_s + nfasc_pkg::SYM_W'(1);
                    n_e     = '0;
                    n_acc   = '0;
                    n_pv    = 1'b0;
                    n_state = S_BSUCC;
                end
            end
            S_RDD: begin
                n_res             = '0;
                n_res.status      = nfasc_pkg::STS_OK;
                n_res.dfa_count   = r_total;
                n_res.has_trash   = r_trash;
                n_res.trash_index = r_trash ? total_m1[nfasc_pkg::IDX_W-1:0] : '0;
                if (rd_in_range) begin
                    if (r_sym < ns_eff) begin
                        // trash row and empty entries both lead to the trash state
                        if (rd_is_trash || t_rdata[TW-1]) begin
                            n_res.next_index = total_m1[nfasc_pkg::IDX_W-1:0];
                        end else begin
                            n_res.next_index = t_rdata[nfasc_pkg::IDX_W-1:0];
                        end
                    end
                    if (!rd_is_trash) begin
                        n_res.is_final    = (s_rdata & r_final) != '0;
                        n_res.subset_mask = s_rdata;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // wait for room in the output register
                if (!r_ov || m_axis_tready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_num_sym <= nfasc_pkg::SYM_W'(26);
            r_num_st  <= nfasc_pkg::NST_W'(64);
            r_init    <= '0;
            r_final   <= '0;
            r_total   <= '0;
            r_head    <= '0;
            r_built   <= 1'b0;
            r_trash   <= 1'b0;
            r_need    <= 1'b0;
            r_pv      <= 1'b0;
            r_clr     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_num_sym <= n_num_sym;
            r_num_st  <= n_num_st;
            r_init    <= n_init;
            r_final   <= n_final;
            r_total   <= n_total;
            r_head    <= n_head;
            r_built   <= n_built;
            r_trash   <= n_trash;
            r_need    <= n_need;
            r_pv      <= n_pv;
            r_clr     <= n_clr;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set   <= n_set;
        r_acc   <= n_acc;
        r_s     <= n_s;
        r_e     <= n_e;
        r_j     <= n_j;
        r_pj    <= n_pj;
        r_pbit  <= n_pbit;
        r_daddr <= n_daddr;
        r_dst   <= n_dst;
        r_idx   <= n_idx;
        r_sym   <= n_sym;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // per-state, per-symbol successor masks
    nfasc_ram #(.WIDTH(MW), .DEPTH(DDEPTH)) u_delta (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // nfa subset of each dfa state
    nfasc_ram #(.WIDTH(MW), .DEPTH(MAX_DFA_STATES)) u_subsets (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // dfa transition table, top bit marks an entry bound for trash
    nfasc_ram #(.WIDTH(TW), .DEPTH(TDEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {5'b0, r_out.subset_mask, r_out.is_final, r_out.next_index,
                            r_out.trash_index, r_out.has_trash, r_out.dfa_count};

endmodule

@@ sv/nfasc_ram.sv @@
// generic single write, single read ram with registered read data
module nfasc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/tb_nfa_subset_construction_unit.sv @@
// self-checking testbench for the nfa subset construction unit
`timescale 1ns / 1ps

module tb_nfa_subset_construction_unit;

    // commands the block must ignore
    localparam logic [nfasc_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [nfasc_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int NSYM       = nfasc_pkg::DEF_MAX_SYMBOLS;
    localparam int NNFA       = nfasc_pkg::DEF_MAX_NFA_STATES;
    localparam int NDFA       = nfasc_pkg::DEF_MAX_DFA_STATES;
    localparam int DRAIN_GAP  = 8;
    localparam int CYCLE_CAP  = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    nfa_subset_construction_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow copy of the nfa stores and the built dfa
    logic [nfasc_pkg::MASK_W-1:0] nfa_rows [NNFA][NSYM];
    logic [nfasc_pkg::MASK_W-1:0] init_set;
    logic [nfasc_pkg::MASK_W-1:0] accept_set;
    logic [nfasc_pkg::MASK_W-1:0] dfa_sets [NDFA];
    logic [nfasc_pkg::IDX_W-1:0]  dfa_next [NDFA][NSYM];
    bit                           goes_dead [NDFA][NSYM];
    int                           dfa_states;
    bit                           dead_state;
    bit                           table_valid;
    logic [nfasc_pkg::SYM_W-1:0]  cfg_symbols;
    logic [nfasc_pkg::NST_W-1:0]  cfg_states;

    nfasc_pkg::t_result           pending_results[$];

    int  errors;
    int  requests_sent;
    int  results_seen;
    int  builds_sent;
    int  overflow_builds;
    int  cycles;
    int  rx_hold;
    bit  no_idle;

    // clock, period 4 ns
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int eff_symbols();
        if (cfg_symbols < 1) return 1;
        if (cfg_symbols > NSYM) return NSYM;
        return int'(cfg_symbols);
    endfunction

    function automatic int eff_states();
        if (cfg_states < 1) return 1;
        if (cfg_states > NNFA) return NNFA;
        return int'(cfg_states);
    endfunction

    function automatic logic [nfasc_pkg::MASK_W-1:0] step_set(
        logic [nfasc_pkg::MASK_W-1:0] set, int sym);
        logic [nfasc_pkg::MASK_W-1:0] acc;
        acc = '0;
        for (int e = 0; e < eff_states(); e++)
            if (set[e]) acc |= nfa_rows[e][sym];
        return acc;
    endfunction

    // breadth-first subset construction, returns 0 on table overflow
    function automatic bit construct_dfa();
        int ns;
        int head;
        int found;
        bit need_dead;
        logic [nfasc_pkg::MASK_W-1:0] dest;
        ns = eff_symbols();
        need_dead = 1'b0;
        dfa_states = 1;
        head = 0;
        dfa_sets[0] = init_set;
        while (head < dfa_states) begin
            for (int s = 0; s < ns; s++) begin
                dest = step_set(dfa_sets[head], s);
                if (dest == '0) begin
                    need_dead = 1'b1;
                    goes_dead[head][s] = 1'b1;
                    continue;
                end
                found = dfa_states;
                for (int j = 0; j < dfa_states; j++)
                    if (dfa_sets[j] == dest) begin
                        found = j;
                        break;
                    end
                if (found == dfa_states) begin
                    if (dfa_states >= NDFA) return 1'b0;
                    dfa_sets[dfa_states] = dest;
                    dfa_states++;
                end
                goes_dead[head][s] = 1'b0;
                dfa_next[head][s] = nfasc_pkg::IDX_W'(found);
            end
            head++;
        end
        dead_state = 1'b0;
        if (need_dead) begin
            if (dfa_states >= NDFA) return 1'b0;
            dead_state = 1'b1;
            dfa_sets[dfa_states] = '0;
            for (int s = 0; s < ns; s++) begin
                goes_dead[dfa_states][s] = 1'b0;
                dfa_next[dfa_states][s] = nfasc_pkg::IDX_W'(dfa_states);
            end
            for (int i = 0; i < dfa_states; i++)
                for (int s = 0; s < ns; s++)
                    if (goes_dead[i][s]) dfa_next[i][s] = nfasc_pkg::IDX_W'(dfa_states);
            dfa_states++;
        end
        return 1'b1;
    endfunction

    // updates the shadow state for one accepted request and queues its result, if it has one
    task automatic apply_request(logic [2:0] cmd, logic [5:0] src, logic [4:0] sym,
                                 logic [5:0] dst, logic [7:0] idx);
        nfasc_pkg::t_result r;
        int dead_idx;
        bit is_dead;
        r = '0;
        case (cmd)
            nfasc_pkg::CMD_LOAD: begin
                if (sym < NSYM) nfa_rows[src][sym][dst] = 1'b1;
                table_valid = 1'b0;
                return;
            end
            nfasc_pkg::CMD_INIT: begin
                init_set[src] = 1'b1;
                table_valid = 1'b0;
                return;
            end
            nfasc_pkg::CMD_FINAL: begin
                accept_set[src] = 1'b1;
                table_valid = 1'b0;
                return;
            end
            nfasc_pkg::CMD_BUILD: begin
                builds_sent++;
                if (!construct_dfa()) begin
                    overflow_builds++;
                    table_valid = 1'b0;
                    dfa_states = 0;
                    dead_state = 1'b0;
                    r.status = nfasc_pkg::STS_OVERFLOW;
                    pending_results.push_back(r);
                    return;
                end
                table_valid = 1'b1;
            end
            nfasc_pkg::CMD_READ: begin
                if (!table_valid) begin
                    r.status = nfasc_pkg::STS_UNBUILT;
                    pending_results.push_back(r);
                    return;
                end
            end
            default: return;
        endcase
        dead_idx = dead_state ? dfa_states - 1 : 0;
        r.status      = nfasc_pkg::STS_OK;
        r.dfa_count   = nfasc_pkg::CNT_W'(dfa_states);
        r.has_trash   = dead_state;
        r.trash_index = nfasc_pkg::IDX_W'(dead_idx);
        if (cmd == nfasc_pkg::CMD_READ && idx < dfa_states) begin
            is_dead = dead_state && idx == dead_idx;
            if (sym < eff_symbols()) r.next_index = dfa_next[idx][sym];
            r.is_final    = !is_dead && (dfa_sets[idx] & accept_set) != '0;
            r.subset_mask = is_dead ? '0 : dfa_sets[idx];
        end
        pending_results.push_back(r);
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        nfasc_pkg::t_result got;
        nfasc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.status      = m_axis_tuser;
            got.dfa_count   = m_axis_tdata[8:0];
            got.has_trash   = m_axis_tdata[9];
            got.trash_index = m_axis_tdata[17:10];
            got.next_index  = m_axis_tdata[25:18];
            got.is_final    = m_axis_tdata[26];
            got.subset_mask = m_axis_tdata[90:27];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result at cycle %0d: %p", cycles, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    // result side backpressure, with a forced hold-off when rx_hold is set
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = no_idle || ($urandom_range(99) >= 32);
        end
    end

    // one request on the stream input, tvalid stays high after acceptance
    task automatic send_request(logic [2:0] cmd, logic [5:0] src, logic [4:0] sym,
                                logic [5:0] dst, logic [7:0] idx);
        bit taken;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 32) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {7'd0, idx, dst, sym, src};
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = s_axis_tready;
        end
        requests_sent++;
        apply_request(cmd, src, sym, dst, idx);
    endtask

    task automatic stream_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        stream_quiet();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [7:0] value);
        bit taken;
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_cfg_ready;
        end
        if (index == nfasc_pkg::REG_NUM_SYMBOLS) cfg_symbols = value[nfasc_pkg::SYM_W-1:0];
        else if (index == nfasc_pkg::REG_NUM_STATES) cfg_states = value[nfasc_pkg::NST_W-1:0];
        table_valid = 1'b0;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic read_entry(int idx, int sym);
        send_request(nfasc_pkg::CMD_READ, 6'($urandom), 5'(sym), 6'($urandom), 8'(idx));
    endtask

    task automatic load(int src, int sym, int dst);
        send_request(nfasc_pkg::CMD_LOAD, 6'(src), 5'(sym), 6'(dst), 8'($urandom));
    endtask

    // unbuilt reads, ignored commands, empty nfa, field extremes at reset settings
    task automatic test_defaults();
        read_entry(0, 0);
        send_request(CMD_RSVD_5, 6'd63, 5'd31, 6'd63, 8'd255);
        send_request(CMD_RSVD_7, 6'd0, 5'd0, 6'd0, 8'd0);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        read_entry(0, 0);
        read_entry(1, 25);
        read_entry(200, 3);
        read_entry(0, 31);
        load(5, 30, 7);             // symbol past the alphabet, ignored but unbuilds
        read_entry(0, 0);
        send_request(nfasc_pkg::CMD_INIT, 6'd0, 5'd0, 6'd0, 8'd0);
        send_request(nfasc_pkg::CMD_FINAL, 6'd51, 5'd0, 6'd0, 8'd0);
        load(0, 25, 50);
        load(50, 24, 51);
        load(51, 25, 50);
        load(63, 24, 63);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        read_entry(0, 25);
        read_entry(1, 24);
        read_entry(2, 25);
        read_entry(3, 0);
        read_entry(255, 31);
    endtask

    // shift-register nfa: exactly 256 subsets, then overflow by trash and by subsets
    task automatic test_table_limits();
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd2);
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd9);
        load(0, 0, 0);
        load(0, 0, 1);
        load(0, 1, 0);
        for (int i = 1; i < 8; i++) begin
            load(i, 0, i + 1);
            load(i, 1, i + 1);
        end
        send_request(nfasc_pkg::CMD_FINAL, 6'd8, 5'd0, 6'd0, 8'd0);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        read_entry(255, 1);
        read_entry(128, 0);
        drain();
        // receiver holds off long enough for the input to back up
        rx_hold = 400;
        for (int i = 0; i < 30; i++) read_entry($urandom_range(255), $urandom_range(1));
        drain();
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd3);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        read_entry(0, 0);
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd2);
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd10);
        load(8, 0, 9);
        load(8, 1, 9);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
    endtask

    // register values below and above the legal range are clamped
    task automatic test_register_clamps();
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd0);
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd127);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        for (int i = 0; i < 6; i++) read_entry(i, $urandom_range(1));
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd31);
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd1);
        send_request(nfasc_pkg::CMD_BUILD, 6'd0, 5'd0, 6'd0, 8'd0);
        for (int i = 0; i < 6; i++) read_entry(i, $urandom_range(25));
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd64);
        write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'd26);
        write_reg(nfasc_pkg::REG_NUM_STATES, 8'd3);
    endtask

    // random small nfas: edits, build, then reads of the new table with occasional loads
    task automatic test_random_nfas(int phases);
        int ns;
        int nst;
        int roll;
        int edits;
        int cnt;
        for (int p = 0; p < phases; p++) begin
            no_idle = (p == 3);
            ns  = $urandom_range(1, 4);
            nst = $urandom_range(2, 5);
            write_reg(nfasc_pkg::REG_NUM_SYMBOLS, 8'(ns));
            write_reg(nfasc_pkg::REG_NUM_STATES, 8'(nst));
            edits = $urandom_range(6, 14);
            for (int k = 0; k < edits; k++) begin
                roll = $urandom_range(99);
                if (roll < 60)
                    load(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(nst - 1),
                         ($urandom_range(19) == 0) ? $urandom_range(26, 31)
                                                   : $urandom_range(ns - 1),
                         ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(nst - 1));
                else if (roll < 75)
                    send_request(nfasc_pkg::CMD_INIT, 6'($urandom_range(nst - 1)), 5'($urandom),
                                 6'($urandom), 8'($urandom));
                else if (roll < 85)
                    send_request(nfasc_pkg::CMD_FINAL, 6'($urandom_range(63)), 5'($urandom),
                                 6'($urandom), 8'($urandom));
                else if (roll < 93)
                    send_request(3'($urandom_range(5, 7)), 6'($urandom), 5'($urandom),
                                 6'($urandom), 8'($urandom));
                else
                    read_entry($urandom_range(255), $urandom_range(31));
            end
            send_request(nfasc_pkg::CMD_BUILD, 6'($urandom), 5'($urandom), 6'($urandom),
                         8'($urandom));
            for (int k = 0; k < 22; k++) begin
                cnt = (dfa_states > 0) ? dfa_states : 1;
                roll = $urandom_range(99);
                if (roll < 3)
                    load($urandom_range(nst - 1), $urandom_range(ns - 1), $urandom_range(63));
                else
                    read_entry((roll < 13) ? $urandom_range(255) : $urandom_range(cnt - 1),
                               (roll > 89) ? $urandom_range(31) : $urandom_range(ns - 1));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        for (int i = 0; i < NNFA; i++)
            for (int s = 0; s < NSYM; s++) nfa_rows[i][s] = '0;
        init_set    = '0;
        accept_set  = '0;
        dfa_states  = 0;
        dead_state  = 1'b0;
        table_valid = 1'b0;
        cfg_symbols = nfasc_pkg::SYM_W'(NSYM);
        cfg_states  = nfasc_pkg::NST_W'(NNFA);
        errors = 0;
        rx_hold = 0;
        no_idle = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_table_limits();
        test_register_clamps();
        test_random_nfas(14);
        drain();

        $display("sent %0d requests, checked %0d results", requests_sent, results_seen);
        $display("%0d builds, %0d of them overflowing; %0d errors", builds_sent,
                 overflow_builds, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
